[rtl/idrm_pkg.sv]
// Shared types and constants for the id range map table.
`timescale 1ns / 1ps
package idrm_pkg;

	localparam int unsigned ID_W = 32;
	localparam logic [ID_W-1:0] ID_NONE = '1;
	localparam logic [ID_W-1:0] OVERFLOW_RESET = 32'd65534;

	typedef enum logic [1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_INSERT   = 2'd1,
		CMD_MAP_UP   = 2'd2,
		CMD_MAP_DOWN = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_BAD       = 3'd2,
		ST_OVERLAP   = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// Transaction token that walks the cell chain.
	typedef struct packed {
		logic            vld;
		cmd_t            cmd;
		logic [ID_W-1:0] id;
		logic [ID_W-1:0] id_last;
		logic [ID_W-1:0] lower_id;
		logic [ID_W-1:0] low_last;
		logic            stop;
		status_t         status;
		logic [ID_W-1:0] mapped;
	} token_t;

endpackage

[rtl/idrm_cell.sv]
// One table entry cell: holds a range and checks the passing transaction against it.
`timescale 1ns / 1ps
module idrm_cell #(
	parameter int IDX = 0,
	parameter int UW  = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [UW-1:0]    used,
	input  idrm_pkg::token_t tok_in,
	output idrm_pkg::token_t tok_out
);
	import idrm_pkg::*;

	logic [ID_W-1:0] up_first_q;
	logic [ID_W-1:0] up_last_q;
	logic [ID_W-1:0] low_first_q;
	logic [ID_W-1:0] low_last_q;
	token_t          tok_q;
	token_t          tok_d;
	logic            active;
	logic            live;
	logic            wr_en;
	logic            meet_up;
	logic            meet_low;
	logic            hit_up;
	logic            hit_down;

	assign active = UW'(IDX) < used;
	assign live   = tok_in.vld && !tok_in.stop;
	assign wr_en  = live && (tok_in.cmd == CMD_INSERT) && (UW'(IDX) == used);

	assign meet_up  = (up_first_q <= tok_in.id_last) && (up_last_q >= tok_in.id);
	assign meet_low = (low_first_q <= tok_in.low_last) && (low_last_q >= tok_in.lower_id);
	assign hit_up   = (tok_in.id >= low_first_q) && (tok_in.id <= low_last_q);
	assign hit_down = (tok_in.id >= up_first_q) && (tok_in.id <= up_last_q)
		&& (tok_in.id_last >= up_first_q) && (tok_in.id_last <= up_last_q);

	always_comb begin
		tok_d = tok_in;
		if (live) begin
			unique case (tok_in.cmd)
				CMD_INSERT: begin
					if (active && (meet_up || meet_low)) begin
						tok_d.status = ST_OVERLAP;
						tok_d.stop   = 1'b1;
					end else if (wr_en) begin
						tok_d.stop = 1'b1;
					end
				end
				CMD_MAP_UP: begin
					if (active && hit_up) begin
						tok_d.mapped = (tok_in.id - low_first_q) + up_first_q;
						tok_d.status = ST_OK;
						tok_d.stop   = 1'b1;
					end
				end
				CMD_MAP_DOWN: begin
					if (active && hit_down) begin
						tok_d.mapped = (tok_in.id - up_first_q) + low_first_q;
						tok_d.status = ST_OK;
						tok_d.stop   = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			up_first_q  <= tok_in.id;
			up_last_q   <= tok_in.id_last;
			low_first_q <= tok_in.lower_id;
			low_last_q  <= tok_in.low_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.vld <= 1'b0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

[rtl/id_range_map_table.sv]
// Top level of the id range map table: command intake, cell chain and result delivery.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid / in_stall) carries one command transaction:
//   command, id, lower_id and range_count. Output channel (out_valid /
//   out_stall) returns one result per command: status, mapped_id and
//   used_count. The cfg channel (cfg_valid / cfg_ready) writes overflow_id;
//   cfg_ready is always high, write it only while the block is idle.
//   Path from input acceptance to out_valid: the intake register loads at
//   the accepting edge, the token walks the chain of MAX_EXTENTS cells, one
//   cell a cycle, then passes the wrap-up and output registers. One command
//   is in flight at a time, so a new command is not taken before the last
//   result reaches the output register; the next one is accepted while the
//   previous result waits at the output.
//   Reset empties the table (used count zero) and restores overflow_id to
//   65534; stored entries are not cleared, since only entries below the used
//   count are ever examined.
//   A stalled output holds its result; a finished result waiting behind it
//   keeps in_stall high until it moves into the output register.
module id_range_map_table #(
	parameter int MAX_EXTENTS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             command,
	input  logic [31:0]                            id,
	input  logic [31:0]                            lower_id,
	input  logic [31:0]                            range_count,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [2:0]                             status,
	output logic [31:0]                            mapped_id,
	output logic [$clog2(MAX_EXTENTS+1)-1:0]       used_count,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [31:0]                            cfg_data
);
	import idrm_pkg::*;

	localparam int UW = $clog2(MAX_EXTENTS + 1);

	logic [ID_W-1:0] overflow_q;
	logic [UW-1:0]   used_q;
	logic            busy_q;

	// Token entering the chain, and the links between cells.
	token_t          tok0_q;
	token_t          tok0_d;
	token_t          links [MAX_EXTENTS+1];
	logic [MAX_EXTENTS:0] link_vld;

	// Finished result waiting for the output register.
	logic            pend_vld_q;
	status_t         pend_status_q;
	logic [ID_W-1:0] pend_mapped_q;
	logic [UW-1:0]   pend_used_q;

	logic            out_vld_q;
	status_t         out_status_q;
	logic [ID_W-1:0] out_mapped_q;
	logic [UW-1:0]   out_used_q;

	logic            in_acc;
	logic            out_load;
	token_t          tail;
	status_t         tail_status;
	logic [UW-1:0]   used_next;

	logic [ID_W:0]   sum_up;
	logic [ID_W:0]   sum_low;
	logic [ID_W-1:0] id_last;
	logic [ID_W-1:0] low_last;
	logic            ins_bad;
	logic            down_ok;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = busy_q;
	assign cfg_ready = 1'b1;
	assign out_load  = pend_vld_q && (!out_vld_q || !out_stall);

	// Intake checks: range sums, wrap detection and span ends.
	assign sum_up   = {1'b0, id} + {1'b0, range_count};
	assign sum_low  = {1'b0, lower_id} + {1'b0, range_count};
	assign id_last  = id + range_count - 32'd1;
	assign low_last = lower_id + range_count - 32'd1;
	assign ins_bad  = (id == ID_NONE) || (lower_id == ID_NONE) || (range_count == '0)
		|| sum_up[ID_W] || sum_low[ID_W];
	assign down_ok  = (range_count != '0) && (!sum_up[ID_W] || (sum_up[ID_W-1:0] == '0));

	always_comb begin
		tok0_d          = '0;
		tok0_d.vld      = 1'b1;
		tok0_d.cmd      = cmd_t'(command);
		tok0_d.id       = id;
		tok0_d.id_last  = id_last;
		tok0_d.lower_id = lower_id;
		tok0_d.low_last = low_last;
		tok0_d.status   = ST_OK;
		unique case (cmd_t'(command))
			CMD_CLEAR: begin
				tok0_d.stop = 1'b1;
			end
			CMD_INSERT: begin
				tok0_d.stop   = ins_bad;
				tok0_d.status = ins_bad ? ST_BAD : ST_OK;
			end
			CMD_MAP_UP: begin
				tok0_d.status = ST_NOT_FOUND;
				tok0_d.mapped = overflow_q;
			end
			CMD_MAP_DOWN: begin
				tok0_d.stop   = !down_ok;
				tok0_d.status = ST_NOT_FOUND;
				tok0_d.mapped = ID_NONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q.vld <= 1'b0;
		end else if (in_acc) begin
			tok0_q <= tok0_d;
		end else begin
			tok0_q.vld <= 1'b0;
		end
	end

	assign links[0] = tok0_q;

	// Chain of entry cells; cell i owns table entry i.
	for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
		idrm_cell #(
			.IDX(g),
			.UW (UW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.used   (used_q),
			.tok_in (links[g]),
			.tok_out(links[g+1])
		);
	end

	for (genvar g = 0; g <= MAX_EXTENTS; g++) begin : g_vld
		assign link_vld[g] = links[g].vld;
	end

	// Wrap up at the tail: an insert that found no free cell is refused as full.
	assign tail = links[MAX_EXTENTS];

	always_comb begin
		tail_status = tail.status;
		used_next   = used_q;
		if (tail.cmd == CMD_CLEAR) begin
			used_next = '0;
		end else if (tail.cmd == CMD_INSERT) begin
			if (!tail.stop) begin
				tail_status = ST_FULL;
			end else if (tail.status == ST_OK) begin
				used_next = used_q + UW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			pend_vld_q <= 1'b0;
		end else if (tail.vld) begin
			used_q     <= used_next;
			pend_vld_q <= 1'b1;
		end else if (out_load) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.vld) begin
			pend_status_q <= tail_status;
			pend_mapped_q <= tail.mapped;
			pend_used_q   <= used_next;
		end
	end

	// Output register: hold while stalled, drop after the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= pend_status_q;
			out_mapped_q <= pend_mapped_q;
			out_used_q   <= pend_used_q;
		end
	end

	// Busy from acceptance until the result reaches the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
		end else if (out_load) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= OVERFLOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			overflow_q <= cfg_data;
		end
	end

	assign out_valid  = out_vld_q;
	assign status     = out_status_q;
	assign mapped_id  = out_mapped_q;
	assign used_count = out_used_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(MAX_EXTENTS))
		else $error("used count beyond table size");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(link_vld) <= 1)
		else $error("more than one transaction in the cell chain");

	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_vld_q || link_vld != '0) |-> busy_q)
		else $error("transaction in flight while not busy");

	a_used_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!tail.vld |=> $stable(used_q))
		else $error("used count changed without a finished transaction");

endmodule
